@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file tsc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

@@ hdl/tsc_pkg.sv @@
`timescale 1ns / 1ps

package tsc_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned POS_W     = 16;
    localparam int unsigned TICK_W    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_MS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_SPEED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_POSITION  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLACE_POSITION = 2'd3;

    localparam logic [POS_W-1:0] DWELL_MS_RESET       = 16'd600;
    localparam logic [POS_W-1:0] SERVO_SPEED_RESET    = 16'd10;
    localparam logic [POS_W-1:0] PICK_POSITION_RESET  = 16'd0;
    localparam logic [POS_W-1:0] PLACE_POSITION_RESET = 16'd150;

    typedef struct packed {
        logic [POS_W-1:0] dwell_ms;
        logic [POS_W-1:0] servo_speed;
        logic [POS_W-1:0] pick_position;
        logic [POS_W-1:0] place_position;
    } t_cfg;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_ALL      = 3'd1,
        CMD_SUPPLY   = 3'd2,
        CMD_CONVEYOR = 3'd3,
        CMD_STOCKER  = 3'd4,
        CMD_STOP     = 3'd5
    } t_cmd;

    localparam int unsigned AUTO_SUPPLY   = 0;
    localparam int unsigned AUTO_CONVEYOR = 1;
    localparam int unsigned AUTO_STOCKER  = 2;

    typedef enum logic [7:0] {
        SUP_START     = 8'd0,
        SUP_FEED      = 8'd100,
        SUP_RETRACT   = 8'd110,
        SUP_DRILL     = 8'd120,
        SUP_WAIT      = 8'd130,
        SUP_EMIT_FWD  = 8'd140,
        SUP_EMIT_BACK = 8'd150
    } t_sup_step;

    typedef enum logic [8:0] {
        CONV_START    = 9'd0,
        CONV_WAIT     = 9'd100,
        CONV_RUN      = 9'd110,
        CONV_SORT     = 9'd120,
        CONV_DWELL    = 9'd200,
        CONV_DIS_FWD  = 9'd210,
        CONV_DIS_BACK = 9'd220,
        CONV_STOPPER  = 9'd300,
        CONV_HOLD     = 9'd310
    } t_conv_step;

    typedef enum logic [7:0] {
        STK_START    = 8'd0,
        STK_WAIT     = 8'd100,
        STK_TO_PICK  = 8'd110,
        STK_GRIP     = 8'd120,
        STK_TO_PLACE = 8'd130,
        STK_PUSH     = 8'd140,
        STK_CHECK    = 8'd150,
        STK_BACK     = 8'd160,
        STK_FWD      = 8'd170,
        STK_RELEASE  = 8'd180
    } t_stk_step;

endpackage

@@ hdl/three_station_sequence_controller.sv @@
`timescale 1ns / 1ps

// Scan controller for a supply, conveyor and stocker line. Each input transaction is one scan;
// it is captured in an input register, and when the result register is free or being taken the
// three step sequencers, the dwell timer and the command update the state registers and load the
// result register, so one scan is taken every clock cycle while the output is not stalled.
// The single pass of sequencer logic between the input register and the state registers sets
// that rate. A stalled result holds in the result register while the next scan is taken into
// the input register. Configuration writes are taken at any time and always complete at once.
module three_station_sequence_controller import tsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [POS_W-1:0]     i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [2:0]           i_command,
    input  logic [7:0]           i_supply_sensors,
    input  logic [4:0]           i_conveyor_sensors,
    input  logic [4:0]           i_stocker_sensors,
    input  logic [POS_W-1:0]     i_servo_position,
    input  logic [TICK_W-1:0]    i_tick_ms,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [5:0]           o_supply_drives,
    output logic [3:0]           o_conveyor_drives,
    output logic [4:0]           o_stocker_drives,
    output logic                 o_axis_run,
    output logic [POS_W-1:0]     o_servo_speed_out,
    output logic [POS_W-1:0]     o_servo_target_out,
    output logic [7:0]           o_supply_step,
    output logic [8:0]           o_conveyor_step,
    output logic [7:0]           o_stocker_step,
    output logic [2:0]           o_auto_flags
);

    t_cfg cfg;

    // Input register
    logic                 r_in_valid;
    logic [2:0]           r_in_cmd;
    logic [7:0]           r_in_sup_sens;
    logic [4:0]           r_in_conv_sens;
    logic [4:0]           r_in_stk_sens;
    logic [POS_W-1:0]     r_in_pos;
    logic [TICK_W-1:0]    r_in_tick;

    // Controller state
    t_sup_step            r_sup_step;
    t_conv_step           r_conv_step;
    t_stk_step            r_stk_step;
    logic [2:0]           r_auto;
    logic [5:0]           r_sup_drv;
    logic [3:0]           r_conv_drv;
    logic [4:0]           r_stk_drv;
    logic                 r_axis;
    logic [POS_W-1:0]     r_speed;
    logic [POS_W-1:0]     r_target;
    logic [POS_W-1:0]     r_dwell;

    // Result register
    logic                 r_out_valid;
    logic [5:0]           r_out_sup_drv;
    logic [3:0]           r_out_conv_drv;
    logic [4:0]           r_out_stk_drv;
    logic                 r_out_axis;
    logic [POS_W-1:0]     r_out_speed;
    logic [POS_W-1:0]     r_out_target;
    logic [7:0]           r_out_sup_step;
    logic [8:0]           r_out_conv_step;
    logic [7:0]           r_out_stk_step;
    logic [2:0]           r_out_auto;

    t_sup_step            seq_sup_step;
    t_sup_step            n_sup_step;
    t_conv_step           n_conv_step;
    t_stk_step            n_stk_step;
    logic [2:0]           n_auto;
    logic [5:0]           n_sup_drv;
    logic [3:0]           n_conv_drv;
    logic [4:0]           n_stk_drv;
    logic                 n_axis;
    logic [POS_W-1:0]     n_speed;
    logic [POS_W-1:0]     n_target;
    logic [POS_W-1:0]     n_dwell;

    logic                 in_accept;
    logic                 advance;

    assign o_cfg_ready = 1'b1;

    tsc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_cmd       <= i_command;
            r_in_sup_sens  <= i_supply_sensors;
            r_in_conv_sens <= i_conveyor_sensors;
            r_in_stk_sens  <= i_stocker_sensors;
            r_in_pos       <= i_servo_position;
            r_in_tick      <= i_tick_ms;
        end
    end

    // Supply sees the conveyor step of the previous scan; conveyor and stocker see
    // the steps already updated in this scan by the sequencers ahead of them.
    tsc_supply_seq u_supply (
        .i_en        (r_auto[AUTO_SUPPLY]),
        .i_step      (r_sup_step),
        .i_conv_step (r_conv_step),
        .i_sensors   (r_in_sup_sens),
        .i_drives    (r_sup_drv),
        .o_step      (seq_sup_step),
        .o_drives    (n_sup_drv)
    );

    tsc_conveyor_seq u_conveyor (
        .i_en       (r_auto[AUTO_CONVEYOR]),
        .i_step     (r_conv_step),
        .i_sup_step (seq_sup_step),
        .i_stk_step (r_stk_step),
        .i_sensors  (r_in_conv_sens),
        .i_drives   (r_conv_drv),
        .i_dwell    (r_dwell),
        .i_tick_ms  (r_in_tick),
        .i_dwell_ms (cfg.dwell_ms),
        .o_step     (n_conv_step),
        .o_drives   (n_conv_drv),
        .o_dwell    (n_dwell)
    );

    tsc_stocker_seq u_stocker (
        .i_en        (r_auto[AUTO_STOCKER]),
        .i_step      (r_stk_step),
        .i_conv_step (n_conv_step),
        .i_sensors   (r_in_stk_sens),
        .i_position  (r_in_pos),
        .i_cfg       (cfg),
        .i_drives    (r_stk_drv),
        .i_axis      (r_axis),
        .i_speed     (r_speed),
        .i_target    (r_target),
        .o_step      (n_stk_step),
        .o_drives    (n_stk_drv),
        .o_axis      (n_axis),
        .o_speed     (n_speed),
        .o_target    (n_target)
    );

    // The command takes effect after all three sequencers have run.
    always_comb begin
        n_auto     = r_auto;
        n_sup_step = seq_sup_step;
        case (t_cmd'(r_in_cmd))
            CMD_ALL:      n_auto = 3'b111;
            CMD_SUPPLY: begin
                n_sup_step          = SUP_START;
                n_auto[AUTO_SUPPLY] = 1'b1;
            end
            CMD_CONVEYOR: n_auto[AUTO_CONVEYOR] = 1'b1;
            CMD_STOCKER:  n_auto[AUTO_STOCKER]  = 1'b1;
            CMD_STOP:     n_auto = 3'b000;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sup_step  <= SUP_START;
            r_conv_step <= CONV_START;
            r_stk_step  <= STK_START;
            r_auto      <= '0;
            r_sup_drv   <= '0;
            r_conv_drv  <= '0;
            r_stk_drv   <= '0;
            r_axis      <= 1'b0;
            r_speed     <= '0;
            r_target    <= '0;
            r_dwell     <= '0;
        end else if (advance) begin
            r_sup_step  <= n_sup_step;
            r_conv_step <= n_conv_step;
            r_stk_step  <= n_stk_step;
            r_auto      <= n_auto;
            r_sup_drv   <= n_sup_drv;
            r_conv_drv  <= n_conv_drv;
            r_stk_drv   <= n_stk_drv;
            r_axis      <= n_axis;
            r_speed     <= n_speed;
            r_target    <= n_target;
            r_dwell     <= n_dwell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_sup_drv   <= n_sup_drv;
            r_out_conv_drv  <= n_conv_drv;
            r_out_stk_drv   <= n_stk_drv;
            r_out_axis      <= n_axis;
            r_out_speed     <= n_speed;
            r_out_target    <= n_target;
            r_out_sup_step  <= n_sup_step;
            r_out_conv_step <= n_conv_step;
            r_out_stk_step  <= n_stk_step;
            r_out_auto      <= n_auto;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_supply_drives    = r_out_sup_drv;
    assign o_conveyor_drives  = r_out_conv_drv;
    assign o_stocker_drives   = r_out_stk_drv;
    assign o_axis_run         = r_out_axis;
    assign o_servo_speed_out  = r_out_speed;
    assign o_servo_target_out = r_out_target;
    assign o_supply_step      = r_out_sup_step;
    assign o_conveyor_step    = r_out_conv_step;
    assign o_stocker_step     = r_out_stk_step;
    assign o_auto_flags       = r_out_auto;

endmodule

@@ hdl/tsc_cfg_regs.sv @@
`timescale 1ns / 1ps

module tsc_cfg_regs import tsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [POS_W-1:0]     i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dwell_ms       <= DWELL_MS_RESET;
            r_cfg.servo_speed    <= SERVO_SPEED_RESET;
            r_cfg.pick_position  <= PICK_POSITION_RESET;
            r_cfg.place_position <= PLACE_POSITION_RESET;
        end else if (i_wr) begin
            case (i_index)
                CFG_DWELL_MS:       r_cfg.dwell_ms       <= i_data;
                CFG_SERVO_SPEED:    r_cfg.servo_speed    <= i_data;
                CFG_PICK_POSITION:  r_cfg.pick_position  <= i_data;
                CFG_PLACE_POSITION: r_cfg.place_position <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/tsc_supply_seq.sv @@
`timescale 1ns / 1ps

module tsc_supply_seq import tsc_pkg::*; (
    input  logic       i_en,
    input  t_sup_step  i_step,
    input  t_conv_step i_conv_step,
    input  logic [7:0] i_sensors,
    input  logic [5:0] i_drives,
    output t_sup_step  o_step,
    output logic [5:0] o_drives
);

    always_comb begin
        o_step = i_step;
        if (i_en) begin
            case (i_step)
                SUP_START:     o_step = SUP_FEED;
                SUP_FEED:      if (i_sensors[1]) o_step = SUP_RETRACT;
                SUP_RETRACT:   if (i_sensors[2]) o_step = SUP_DRILL;
                SUP_DRILL:     if (i_sensors[4]) o_step = SUP_WAIT;
                SUP_WAIT: begin
                    // Wait for the conveyor to be ready before emitting the part.
                    if (!i_sensors[3]) begin
                        o_step = SUP_START;
                    end else if (i_sensors[5] && i_conv_step == CONV_WAIT) begin
                        o_step = SUP_EMIT_FWD;
                    end
                end
                SUP_EMIT_FWD:  if (i_sensors[6]) o_step = SUP_EMIT_BACK;
                SUP_EMIT_BACK: if (i_sensors[7]) o_step = SUP_START;
                default:       o_step = SUP_START;
            endcase
        end
    end

    always_comb begin
        o_drives = i_drives;
        if (i_en) begin
            case (i_step)
                SUP_FEED: begin
                    if (i_sensors[0]) o_drives[0] = 1'b1;
                    if (i_sensors[1]) o_drives[0] = 1'b0;
                end
                SUP_RETRACT:   o_drives[1] = !i_sensors[2];
                SUP_DRILL: begin
                    if (i_sensors[3]) o_drives[3:2] = 2'b11;
                    if (i_sensors[4]) o_drives[3:2] = 2'b00;
                end
                SUP_EMIT_FWD:  o_drives[4] = !i_sensors[6];
                SUP_EMIT_BACK: o_drives[5] = !i_sensors[7];
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/tsc_conveyor_seq.sv @@
`timescale 1ns / 1ps

module tsc_conveyor_seq import tsc_pkg::*; (
    input  logic              i_en,
    input  t_conv_step        i_step,
    input  t_sup_step         i_sup_step,
    input  t_stk_step         i_stk_step,
    input  logic [4:0]        i_sensors,
    input  logic [3:0]        i_drives,
    input  logic [POS_W-1:0]  i_dwell,
    input  logic [TICK_W-1:0] i_tick_ms,
    input  logic [POS_W-1:0]  i_dwell_ms,
    output t_conv_step        o_step,
    output logic [3:0]        o_drives,
    output logic [POS_W-1:0]  o_dwell
);

    logic [POS_W:0]   sum;
    logic [POS_W-1:0] dwell_sat;

    // The dwell timer runs on every scan, whether or not the conveyor is in auto.
    assign sum       = {1'b0, i_dwell} + {{(POS_W + 1 - TICK_W){1'b0}}, i_tick_ms};
    assign dwell_sat = sum[POS_W] ? {POS_W{1'b1}} : sum[POS_W-1:0];

    always_comb begin
        o_step = i_step;
        if (i_en) begin
            case (i_step)
                CONV_START:    o_step = CONV_WAIT;
                CONV_WAIT:     if (i_sup_step == SUP_EMIT_BACK) o_step = CONV_RUN;
                CONV_RUN:      if (i_sensors[0]) o_step = CONV_SORT;
                CONV_SORT:     o_step = i_sensors[1] ? CONV_DWELL : CONV_STOPPER;
                CONV_DWELL:    if (dwell_sat > i_dwell_ms) o_step = CONV_DIS_FWD;
                CONV_DIS_FWD:  if (i_sensors[2]) o_step = CONV_DIS_BACK;
                CONV_DIS_BACK: if (i_sensors[3]) o_step = CONV_START;
                CONV_STOPPER:  if (i_sensors[4]) o_step = CONV_HOLD;
                CONV_HOLD:     if (i_stk_step == STK_TO_PLACE) o_step = CONV_START;
                default:       o_step = CONV_START;
            endcase
        end
    end

    always_comb begin
        o_drives = i_drives;
        o_dwell  = dwell_sat;
        if (i_en) begin
            case (i_step)
                CONV_RUN:      o_drives[0] = 1'b1;
                CONV_SORT:     o_dwell = '0;
                CONV_DWELL:    if (dwell_sat > i_dwell_ms) o_drives[0] = 1'b0;
                CONV_DIS_FWD:  o_drives[1] = !i_sensors[2];
                CONV_DIS_BACK: o_drives[2] = !i_sensors[3];
                CONV_STOPPER: begin
                    o_drives[3] = 1'b1;
                    if (i_sensors[4]) begin
                        o_drives[0] = 1'b0;
                        o_drives[3] = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/tsc_stocker_seq.sv @@
`timescale 1ns / 1ps

module tsc_stocker_seq import tsc_pkg::*; (
    input  logic             i_en,
    input  t_stk_step        i_step,
    input  t_conv_step       i_conv_step,
    input  logic [4:0]       i_sensors,
    input  logic [POS_W-1:0] i_position,
    input  t_cfg             i_cfg,
    input  logic [4:0]       i_drives,
    input  logic             i_axis,
    input  logic [POS_W-1:0] i_speed,
    input  logic [POS_W-1:0] i_target,
    output t_stk_step        o_step,
    output logic [4:0]       o_drives,
    output logic             o_axis,
    output logic [POS_W-1:0] o_speed,
    output logic [POS_W-1:0] o_target
);

    logic at_pick;
    logic at_place;

    assign at_pick  = (i_position == i_cfg.pick_position);
    assign at_place = (i_position == i_cfg.place_position);

    always_comb begin
        o_step = i_step;
        if (i_en) begin
            case (i_step)
                STK_START:    o_step = STK_WAIT;
                STK_WAIT:     if (i_conv_step == CONV_HOLD) o_step = STK_TO_PICK;
                STK_TO_PICK:  if (at_pick) o_step = STK_GRIP;
                STK_GRIP:     if (i_sensors[0]) o_step = STK_TO_PLACE;
                STK_TO_PLACE: if (at_place) o_step = STK_PUSH;
                STK_PUSH:     if (i_sensors[1]) o_step = STK_CHECK;
                STK_CHECK: begin
                    if (i_sensors[3]) begin
                        o_step = STK_BACK;
                    end else if (i_sensors[4]) begin
                        o_step = STK_FWD;
                    end
                end
                STK_BACK:     if (i_sensors[4]) o_step = STK_RELEASE;
                STK_FWD:      if (i_sensors[3]) o_step = STK_RELEASE;
                STK_RELEASE:  if (i_sensors[2]) o_step = STK_START;
                default:      o_step = STK_START;
            endcase
        end
    end

    always_comb begin
        o_drives = i_drives;
        o_axis   = i_axis;
        o_speed  = i_speed;
        o_target = i_target;
        if (i_en) begin
            case (i_step)
                STK_TO_PICK: begin
                    // The run request drops in the same scan the axis arrives.
                    o_speed  = i_cfg.servo_speed;
                    o_target = i_cfg.pick_position;
                    o_axis   = !at_pick;
                end
                STK_GRIP:     o_drives[0] = 1'b1;
                STK_TO_PLACE: begin
                    o_speed  = i_cfg.servo_speed;
                    o_target = i_cfg.place_position;
                    o_axis   = !at_place;
                end
                STK_PUSH: begin
                    o_drives[1] = 1'b1;
                    if (i_sensors[1]) o_drives[1:0] = 2'b00;
                end
                STK_BACK:     o_drives[4] = !i_sensors[4];
                STK_FWD:      o_drives[3] = !i_sensors[3];
                STK_RELEASE:  o_drives[2] = !i_sensors[2];
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/tsc_checker.sv @@
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tsc_checker import tsc_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [5:0]           o_supply_drives,
    input logic [3:0]           o_conveyor_drives,
    input logic [4:0]           o_stocker_drives,
    input logic [7:0]           o_supply_step,
    input logic [8:0]           o_conveyor_step,
    input logic [7:0]           o_stocker_step
);

    // A waiting result transaction keeps its contents until it is taken.
    `ASSERT_CLKD(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_supply_step) && $stable(o_conveyor_step) && $stable(o_stocker_step) && $stable(o_stocker_drives))

    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

    // The discharge and vacuum pushers extend only in their own steps and retract on leaving.
    `ASSERT_CLKD(a_dis_fwd_step, i_clk, i_rst_n, o_out_valid && o_conveyor_drives[1] |-> o_conveyor_step == CONV_DIS_FWD)

    `ASSERT_CLKD(a_vac_fwd_step, i_clk, i_rst_n, o_out_valid && o_stocker_drives[1] |-> o_stocker_step == STK_PUSH)

    // Work down and drill are always switched together.
    `ASSERT_CLKD(a_drill_pair, i_clk, i_rst_n, o_out_valid |-> o_supply_drives[2] == o_supply_drives[3])

endmodule

bind three_station_sequence_controller tsc_checker u_tsc_checker (.*);
